/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dmds_pkg.sv */
// ----------------------------------------------------------------------------
// dmds_pkg
// Types, widths and codes shared by the dual motor drive shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package dmds_pkg;

  // Field widths
  localparam int MV_W      = 15;
  localparam int SP_W      = 16;
  localparam int GAIN_W    = 20;
  localparam int RATE_W    = 16;
  localparam int ELAPSED_W = 16;
  localparam int LIMIT_W   = RATE_W + ELAPSED_W - 10;
  localparam int DUTY_W    = 8;
  localparam int BRIDGE_W  = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam int DEF_PWM_FULL_SCALE = 255;

  // Bridge patterns
  localparam logic [BRIDGE_W-1:0] BRIDGE_BRAKE     = 4'h0;
  localparam logic [BRIDGE_W-1:0] BRIDGE_FREEWHEEL = 4'hF;

  // Register indexes
  localparam logic [2:0] REG_DEADBAND = 3'd0;
  localparam logic [2:0] REG_CLAMP    = 3'd1;
  localparam logic [2:0] REG_GAIN     = 3'd2;
  localparam logic [2:0] REG_RATE     = 3'd3;
  localparam logic [2:0] REG_SLEW_EN  = 3'd4;
  localparam logic [2:0] REG_INVERT   = 3'd5;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_BRAKE     = 2'd1,
    CMD_FREEWHEEL = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_RUNNING   = 2'd0,
    MODE_BRAKING   = 2'd1,
    MODE_FREEWHEEL = 2'd2
  } mode_t;

  typedef struct packed {
    logic [MV_W-1:0]   deadband_mv;
    logic [MV_W-1:0]   clamp_mv;
    logic [GAIN_W-1:0] pwm_gain_q16;
    logic [RATE_W-1:0] slew_rate;
    logic              slew_enable;
    logic [1:0]        invert_mask;
  } cfg_t;

  // Shaped request handed from the shaping stage to the PWM scaling stage
  typedef struct packed {
    logic                valid;
    logic                brake;
    logic [BRIDGE_W-1:0] bridge;
    logic [MV_W-1:0]     left_mag;
    logic [MV_W-1:0]     right_mag;
  } shaped_t;

endpackage

`default_nettype wire

/* sv/dmds_if.sv */
// ----------------------------------------------------------------------------
// dmds channel interfaces
// Valid/ready channels for command requests and bridge results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmds_item_if;
  import dmds_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [SP_W-1:0]      left_setpoint_mv;
  logic signed [SP_W-1:0]      right_setpoint_mv;
  logic [ELAPSED_W-1:0]        elapsed_us;

  modport source (output valid, command, left_setpoint_mv, right_setpoint_mv,
                  elapsed_us, input ready);
  modport sink   (input valid, command, left_setpoint_mv, right_setpoint_mv,
                  elapsed_us, output ready);
endinterface

interface dmds_result_if;
  import dmds_pkg::*;

  logic                valid;
  logic                ready;
  logic [BRIDGE_W-1:0] bridge_inputs;
  logic [DUTY_W-1:0]   enable_left;
  logic [DUTY_W-1:0]   enable_right;

  modport source (output valid, bridge_inputs, enable_left, enable_right,
                  input ready);
  modport sink   (input valid, bridge_inputs, enable_left, enable_right,
                  output ready);
endinterface

`default_nettype wire

/* sv/dmds_cfg.sv */
// ----------------------------------------------------------------------------
// dmds_cfg
// APB register file for the shaper settings.
// ----------------------------------------------------------------------------
`default_nettype none

module dmds_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dmds_pkg::ADDR_W-1:0] paddr,
  input  logic [dmds_pkg::DATA_W-1:0] pwdata,
  output logic [dmds_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dmds_pkg::cfg_t              cfg
);
  import dmds_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_mv  <= '0;
      cfg.clamp_mv     <= '1;
      cfg.pwm_gain_q16 <= '0;
      cfg.slew_rate    <= '0;
      cfg.slew_enable  <= 1'b0;
      cfg.invert_mask  <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DEADBAND: cfg.deadband_mv  <= pwdata[MV_W-1:0];
        REG_CLAMP:    cfg.clamp_mv     <= pwdata[MV_W-1:0];
        REG_GAIN:     cfg.pwm_gain_q16 <= pwdata[GAIN_W-1:0];
        REG_RATE:     cfg.slew_rate    <= pwdata[RATE_W-1:0];
        REG_SLEW_EN:  cfg.slew_enable  <= pwdata[0];
        REG_INVERT:   cfg.invert_mask  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_DEADBAND: prdata = DATA_W'(cfg.deadband_mv);
      REG_CLAMP:    prdata = DATA_W'(cfg.clamp_mv);
      REG_GAIN:     prdata = DATA_W'(cfg.pwm_gain_q16);
      REG_RATE:     prdata = DATA_W'(cfg.slew_rate);
      REG_SLEW_EN:  prdata = DATA_W'(cfg.slew_enable);
      REG_INVERT:   prdata = DATA_W'(cfg.invert_mask);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/dmds_shape.sv */
// ----------------------------------------------------------------------------
// dmds_shape
// Input register with slew step product, drive state, and magnitude shaping.
// ----------------------------------------------------------------------------
`default_nettype none

module dmds_shape (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             accept,
  input  logic [1:0]                       command,
  input  logic signed [dmds_pkg::SP_W-1:0] left_setpoint_mv,
  input  logic signed [dmds_pkg::SP_W-1:0] right_setpoint_mv,
  input  logic [dmds_pkg::ELAPSED_W-1:0]   elapsed_us,
  input  dmds_pkg::cfg_t                   cfg,
  output dmds_pkg::shaped_t                shaped
);
  import dmds_pkg::*;

  // Input stage
  logic                      s1_valid;
  cmd_t                      s1_cmd;
  logic signed [SP_W-1:0]    s1_left;
  logic signed [SP_W-1:0]    s1_right;
  logic [LIMIT_W-1:0]        s1_limit;
  logic [RATE_W+ELAPSED_W-1:0] step_prod;

  // Drive state
  mode_t                     drive_mode, drive_mode_next;
  logic signed [SP_W-1:0]    left_target, left_target_next;
  logic signed [SP_W-1:0]    right_target, right_target_next;
  logic [MV_W-1:0]           left_applied, left_applied_next;
  logic [MV_W-1:0]           right_applied, right_applied_next;

  logic [MV_W-1:0]           left_mag, right_mag;
  logic                      left_fwd, right_fwd;
  shaped_t                   shaped_next;

  // Deadband, clamp and slew limit one motor's magnitude
  function automatic logic [MV_W-1:0] shape_mag(
    input logic signed [SP_W-1:0] target,
    input logic [MV_W-1:0]        applied,
    input logic [LIMIT_W-1:0]     limit,
    input cfg_t                   c
  );
    logic [SP_W-1:0] mag;
    logic [MV_W-1:0] m;
    mag = target[SP_W-1] ? SP_W'(-target) : SP_W'(target);
    if (mag < {1'b0, c.deadband_mv}) begin
      m = '0;
    end else if (mag > {1'b0, c.clamp_mv}) begin
      m = c.clamp_mv;
    end else begin
      m = mag[MV_W-1:0];
    end
    if (c.slew_enable) begin
      if (m > applied && LIMIT_W'(m - applied) > limit) begin
        m = applied + limit[MV_W-1:0];
      end else if (applied > m && LIMIT_W'(applied - m) > limit) begin
        m = applied - limit[MV_W-1:0];
      end
    end
    return m;
  endfunction

  // Allowed step per tick: rate times elapsed, in units of 1024 us
  assign step_prod = cfg.slew_rate * elapsed_us;

  // Capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd   <= cmd_t'(command);
      s1_left  <= left_setpoint_mv;
      s1_right <= right_setpoint_mv;
      s1_limit <= step_prod[RATE_W+ELAPSED_W-1:10];
    end
  end

  assign left_mag  = shape_mag(left_target, left_applied, s1_limit, cfg);
  assign right_mag = shape_mag(right_target, right_applied, s1_limit, cfg);
  assign left_fwd  = left_target[SP_W-1] ^ cfg.invert_mask[0];
  assign right_fwd = right_target[SP_W-1] ^ cfg.invert_mask[1];

  // Decode command, update state and build the bridge pattern
  always_comb begin
    drive_mode_next    = drive_mode;
    left_target_next   = left_target;
    right_target_next  = right_target;
    left_applied_next  = left_applied;
    right_applied_next = right_applied;
    shaped_next        = '0;
    if (s1_valid) begin
      unique case (s1_cmd)
        CMD_SET: begin
          left_target_next  = s1_left;
          right_target_next = s1_right;
          drive_mode_next   = MODE_RUNNING;
        end
        CMD_BRAKE, CMD_FREEWHEEL: begin
          drive_mode_next    = (s1_cmd == CMD_BRAKE) ? MODE_BRAKING : MODE_FREEWHEEL;
          left_applied_next  = '0;
          right_applied_next = '0;
          shaped_next.valid  = 1'b1;
          shaped_next.brake  = (s1_cmd == CMD_BRAKE);
          shaped_next.bridge = (s1_cmd == CMD_BRAKE) ? BRIDGE_BRAKE : BRIDGE_FREEWHEEL;
        end
        CMD_TICK: begin
          shaped_next.valid = 1'b1;
          if (drive_mode != MODE_RUNNING) begin
            // Repeat the fixed pattern of the current mode
            left_applied_next  = '0;
            right_applied_next = '0;
            shaped_next.brake  = (drive_mode != MODE_FREEWHEEL);
            shaped_next.bridge = (drive_mode == MODE_FREEWHEEL) ? BRIDGE_FREEWHEEL
                                                                : BRIDGE_BRAKE;
          end else begin
            left_applied_next     = left_mag;
            right_applied_next    = right_mag;
            shaped_next.left_mag  = left_mag;
            shaped_next.right_mag = right_mag;
            if (left_mag != '0) begin
              shaped_next.bridge[0] = left_fwd;
              shaped_next.bridge[1] = !left_fwd;
            end
            if (right_mag != '0) begin
              shaped_next.bridge[2] = right_fwd;
              shaped_next.bridge[3] = !right_fwd;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State and stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode    <= MODE_BRAKING;
      left_target   <= '0;
      right_target  <= '0;
      left_applied  <= '0;
      right_applied <= '0;
      shaped.valid  <= 1'b0;
    end else if (advance) begin
      drive_mode    <= drive_mode_next;
      left_target   <= left_target_next;
      right_target  <= right_target_next;
      left_applied  <= left_applied_next;
      right_applied <= right_applied_next;
      shaped        <= shaped_next;
    end
  end

endmodule

`default_nettype wire

/* sv/dmds_scale.sv */
// ----------------------------------------------------------------------------
// dmds_scale
// PWM duty scaling with saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmds_scale #(
  parameter int PWM_FULL_SCALE = dmds_pkg::DEF_PWM_FULL_SCALE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [dmds_pkg::GAIN_W-1:0]   pwm_gain_q16,
  input  dmds_pkg::shaped_t             shaped,
  output logic                          result_valid,
  output logic [dmds_pkg::BRIDGE_W-1:0] bridge_inputs,
  output logic [dmds_pkg::DUTY_W-1:0]   enable_left,
  output logic [dmds_pkg::DUTY_W-1:0]   enable_right
);
  import dmds_pkg::*;

  localparam int PROD_W = MV_W + GAIN_W;
  localparam logic [DUTY_W-1:0] FULL_DUTY =
    DUTY_W'((PWM_FULL_SCALE > 255) ? 255 : PWM_FULL_SCALE);

  logic [PROD_W-1:0] left_prod, right_prod;
  logic [DUTY_W-1:0] left_duty, right_duty;

  // Scale millivolts by the Q16 gain and saturate
  assign left_prod  = shaped.left_mag * pwm_gain_q16;
  assign right_prod = shaped.right_mag * pwm_gain_q16;

  assign left_duty  = (left_prod[PROD_W-1:16] > (PROD_W-16)'(FULL_DUTY))
                      ? FULL_DUTY : left_prod[16 +: DUTY_W];
  assign right_duty = (right_prod[PROD_W-1:16] > (PROD_W-16)'(FULL_DUTY))
                      ? FULL_DUTY : right_prod[16 +: DUTY_W];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= shaped.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bridge_inputs <= shaped.bridge;
      enable_left   <= shaped.brake ? FULL_DUTY : left_duty;
      enable_right  <= shaped.brake ? FULL_DUTY : right_duty;
    end
  end

endmodule

`default_nettype wire

/* sv/dual_motor_drive_shaper.sv */
// Two-motor H-bridge drive shaper. Requests enter on the item channel (set
// setpoints, brake, freewheel, tick) and bridge patterns leave on the result
// channel, one result per brake, freewheel or tick request and none for set.
// One request is accepted every clock unless a result is stalled; each one
// passes the input register, which takes the slew step product, the shaping
// stage, which applies deadband, clamp and slew limit and updates the drive
// state, and the scaling stage, which multiplies by the PWM gain into the
// result register. A stalled result holds the whole pipe. The user is to write
// settings over the APB port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
// dual_motor_drive_shaper
// Top level: APB settings, shaping pipeline and result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dual_motor_drive_shaper #(
  parameter int PWM_FULL_SCALE = dmds_pkg::DEF_PWM_FULL_SCALE
) (
  input  logic                        clk,
  input  logic                        rst,
  dmds_item_if.sink                   item,
  dmds_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dmds_pkg::ADDR_W-1:0] paddr,
  input  logic [dmds_pkg::DATA_W-1:0] pwdata,
  output logic [dmds_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dmds_pkg::*;

  cfg_t    cfg;
  shaped_t shaped;
  logic    advance;
  logic    accept;

  // Advance the pipe unless a finished result is waiting
  assign advance    = !result.valid || result.ready;
  assign item.ready = advance;
  assign accept     = item.valid && advance;

  dmds_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmds_shape u_shape (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .accept            (accept),
    .command           (item.command),
    .left_setpoint_mv  (item.left_setpoint_mv),
    .right_setpoint_mv (item.right_setpoint_mv),
    .elapsed_us        (item.elapsed_us),
    .cfg               (cfg),
    .shaped            (shaped)
  );

  dmds_scale #(
    .PWM_FULL_SCALE (PWM_FULL_SCALE)
  ) u_scale (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .pwm_gain_q16  (cfg.pwm_gain_q16),
    .shaped        (shaped),
    .result_valid  (result.valid),
    .bridge_inputs (result.bridge_inputs),
    .enable_left   (result.enable_left),
    .enable_right  (result.enable_right)
  );

  // Both left inputs high only in freewheel, which drives no enable
  `ASSERT_IMPLY(a_left_pair_freewheel, result.valid && result.bridge_inputs[1:0] == 2'b11, result.bridge_inputs == BRIDGE_FREEWHEEL && result.enable_left == '0 && result.enable_right == '0, "left pair high outside freewheel")
  // A running motor left off carries no duty
  `ASSERT_IMPLY(a_left_off_no_duty, result.valid && result.bridge_inputs[1:0] == 2'b00 && result.bridge_inputs[3:2] != 2'b00, result.enable_left == '0, "left duty without direction")
  // A stalled result stays valid until it is taken
  `ASSERT_NEXT(a_stall_holds_result, result.valid && !result.ready, result.valid, "pending result dropped")

endmodule

`default_nettype wire

/* tb/dual_motor_drive_shaper_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_drive_shaper_test
// Self-checking bench for the dual motor drive shaper. Requests are queued
// by the main sequence and fed by a clocked driver. A clocked monitor takes
// the bridge results. Each accepted request runs through a local copy of
// the drive behavior: mode, targets and applied magnitudes, deadband, clamp,
// slew limit and PWM scaling. The expected bridge patterns are compared
// field by field in order. Settings are changed over APB between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module dual_motor_drive_shaper_test;
  import dmds_pkg::*;

  localparam int FULL_DUTY = (DEF_PWM_FULL_SCALE > 255) ? 255 : DEF_PWM_FULL_SCALE;
  localparam int SETTLE_CYCLES = 6;

  // Bridge input bits per motor and direction
  localparam logic [BRIDGE_W-1:0] LEFT_FWD  = 4'b0001;
  localparam logic [BRIDGE_W-1:0] LEFT_REV  = 4'b0010;
  localparam logic [BRIDGE_W-1:0] RIGHT_FWD = 4'b0100;
  localparam logic [BRIDGE_W-1:0] RIGHT_REV = 4'b1000;

  typedef struct {
    cmd_t                   command;
    logic signed [SP_W-1:0] left_mv;
    logic signed [SP_W-1:0] right_mv;
    logic [ELAPSED_W-1:0]   elapsed;
  } drive_req_t;

  typedef struct {
    logic [BRIDGE_W-1:0] bridge;
    logic [DUTY_W-1:0]   left_duty;
    logic [DUTY_W-1:0]   right_duty;
  } bridge_out_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  dmds_item_if   req_ch ();
  dmds_result_if res_ch ();

  dual_motor_drive_shaper dut (
    .clk     (clk),
    .rst     (rst),
    .item    (req_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the settings and of the drive state
  cfg_t                   cfg;
  mode_t                  drive_mode;
  logic signed [SP_W-1:0] left_tgt;
  logic signed [SP_W-1:0] right_tgt;
  logic [MV_W-1:0]        left_app;
  logic [MV_W-1:0]        right_app;

  drive_req_t  request_backlog[$];
  bridge_out_t bridge_due[$];
  int          requests_queued;
  int          requests_taken;
  int          mismatches;
  logic        idle_gaps;

  // ---------------------------------------------------------------- predictor

  function automatic logic [DUTY_W-1:0] duty_for(logic [MV_W-1:0] mag);
    longint prod;
    prod = (longint'(mag) * longint'(cfg.pwm_gain_q16)) >>> 16;
    return (prod > FULL_DUTY) ? DUTY_W'(FULL_DUTY) : prod[DUTY_W-1:0];
  endfunction

  function automatic logic [MV_W-1:0] trim_mag(logic signed [SP_W-1:0] tgt,
                                                logic [MV_W-1:0] app, longint step);
    longint m;
    longint a;
    m = (tgt < 0) ? -longint'(tgt) : longint'(tgt);
    a = longint'(app);
    if (m < longint'(cfg.deadband_mv)) m = 0;
    else if (m > longint'(cfg.clamp_mv)) m = longint'(cfg.clamp_mv);
    if (cfg.slew_enable) begin
      if (m > a && m - a > step) m = a + step;
      else if (a > m && a - m > step) m = a - step;
    end
    return m[MV_W-1:0];
  endfunction

  // Brake or freewheel pattern; drops the applied magnitudes
  function automatic bridge_out_t held_pattern();
    bridge_out_t o;
    left_app = '0;
    right_app = '0;
    if (drive_mode == MODE_FREEWHEEL) begin
      o.bridge = BRIDGE_FREEWHEEL;
      o.left_duty = '0;
      o.right_duty = '0;
    end else begin
      o.bridge = BRIDGE_BRAKE;
      o.left_duty = DUTY_W'(FULL_DUTY);
      o.right_duty = DUTY_W'(FULL_DUTY);
    end
    return o;
  endfunction

  function automatic void shape_request(drive_req_t r);
    bridge_out_t o;
    longint step;
    case (r.command)
      CMD_SET: begin
        left_tgt = r.left_mv;
        right_tgt = r.right_mv;
        drive_mode = MODE_RUNNING;
      end
      CMD_BRAKE, CMD_FREEWHEEL: begin
        drive_mode = (r.command == CMD_BRAKE) ? MODE_BRAKING : MODE_FREEWHEEL;
        bridge_due.push_back(held_pattern());
      end
      default: begin
        if (drive_mode != MODE_RUNNING) begin
          bridge_due.push_back(held_pattern());
        end else begin
          step = (longint'(cfg.slew_rate) * longint'(r.elapsed)) >>> 10;
          left_app = trim_mag(left_tgt, left_app, step);
          right_app = trim_mag(right_tgt, right_app, step);
          o.bridge = '0;
          o.left_duty = '0;
          o.right_duty = '0;
          if (left_app != 0) begin
            o.bridge |= ((left_tgt < 0) ^ cfg.invert_mask[0]) ? LEFT_FWD : LEFT_REV;
            o.left_duty = duty_for(left_app);
          end
          if (right_app != 0) begin
            o.bridge |= ((right_tgt < 0) ^ cfg.invert_mask[1]) ? RIGHT_FWD : RIGHT_REV;
            o.right_duty = duty_for(right_app);
          end
          bridge_due.push_back(o);
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------------- driver

  drive_req_t in_flight;
  int         send_gap;
  int         sent;
  logic       drain_wait;

  // Offer queued requests; predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
      sent = 0;
      drain_wait = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        shape_request(in_flight);
        requests_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (drain_wait && bridge_due.size() == 0) drain_wait = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (!drain_wait && request_backlog.size() > 0) begin
          in_flight = request_backlog.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.command <= in_flight.command;
          req_ch.left_setpoint_mv <= in_flight.left_mv;
          req_ch.right_setpoint_mv <= in_flight.right_mv;
          req_ch.elapsed_us <= in_flight.elapsed;
          send_gap = idle_gaps ? $urandom_range(0, 10) : 0;
          sent++;
          // Now and then hold off until every pending result is back
          if (sent == 100 || $urandom_range(0, 59) == 0) drain_wait = 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  int          results_taken;
  int          hold_left;
  bridge_out_t got;
  bridge_out_t want;

  // Take results, compare with the oldest expectation, draw the next stall
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      results_taken = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.bridge = res_ch.bridge_inputs;
        got.left_duty = res_ch.enable_left;
        got.right_duty = res_ch.enable_right;
        if (bridge_due.size() == 0) begin
          $error("unexpected bridge result %h/%h/%h",
                 got.bridge, got.left_duty, got.right_duty);
          mismatches++;
        end else begin
          want = bridge_due.pop_front();
          if (got.bridge !== want.bridge) begin
            $error("bridge_inputs: expected %h, got %h", want.bridge, got.bridge);
            mismatches++;
          end
          if (got.left_duty !== want.left_duty) begin
            $error("enable_left: expected %0d, got %0d", want.left_duty, got.left_duty);
            mismatches++;
          end
          if (got.right_duty !== want.right_duty) begin
            $error("enable_right: expected %0d, got %0d", want.right_duty, got.right_duty);
            mismatches++;
          end
        end
        results_taken++;
        // Long stall fills the pipe and backs up the request side
        if (results_taken == 50 || $urandom_range(0, 199) == 0)
          hold_left = $urandom_range(80, 150);
        else
          hold_left = idle_gaps ? $urandom_range(0, 10) : 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      res_ch.ready <= (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEADBAND: cfg.deadband_mv = value[MV_W-1:0];
      REG_CLAMP:    cfg.clamp_mv = value[MV_W-1:0];
      REG_GAIN:     cfg.pwm_gain_q16 = value[GAIN_W-1:0];
      REG_RATE:     cfg.slew_rate = value[RATE_W-1:0];
      REG_SLEW_EN:  cfg.slew_enable = value[0];
      REG_INVERT:   cfg.invert_mask = value[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int deadband, int clamp, int gain, int rate, int slew, int inv);
    write_reg(REG_DEADBAND, deadband);
    write_reg(REG_CLAMP, clamp);
    write_reg(REG_GAIN, gain);
    write_reg(REG_RATE, rate);
    write_reg(REG_SLEW_EN, slew);
    write_reg(REG_INVERT, inv);
  endtask

  function automatic void push_req(cmd_t c, int l, int r, int e);
    drive_req_t q;
    q.command = c;
    q.left_mv = l;
    q.right_mv = r;
    q.elapsed = e;
    request_backlog.push_back(q);
    requests_queued++;
  endfunction

  // Setpoints cluster on the deadband and clamp edges, else anything or up to 4000
  function automatic int pick_setpoint();
    int mag;
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: mag = int'(cfg.deadband_mv) + int'($urandom_range(0, 4)) - 2;
      2: mag = int'(cfg.clamp_mv) + int'($urandom_range(0, 4)) - 2;
      default: mag = $urandom_range(0, 4000);
    endcase
    if (mag < 0) mag = 0;
    if (mag > 32767) mag = 32767;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic int pick_elapsed();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 64);
      2: return $urandom_range(0, 3000);
      default: return 65535;
    endcase
  endfunction

  // Mostly set-then-ticks runs, the rest any command with any fields
  task automatic queue_random(int count);
    int left_to_go;
    int run_len;
    left_to_go = count;
    while (left_to_go > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        push_req(CMD_SET, pick_setpoint(), pick_setpoint(), $urandom_range(0, 65535));
        run_len = $urandom_range(1, 8);
        repeat (run_len) push_req(CMD_TICK, $urandom_range(0, 65535) - 32768,
                                  $urandom_range(0, 65535) - 32768, pick_elapsed());
        left_to_go -= run_len + 1;
      end else begin
        push_req(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 65535) - 32768,
                 $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535));
        left_to_go--;
      end
    end
  endtask

  // Wait for every request and result, then let the pipe drain
  task automatic settle();
    while (requests_taken != requests_queued || bridge_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_SET;
    req_ch.left_setpoint_mv = '0;
    req_ch.right_setpoint_mv = '0;
    req_ch.elapsed_us = '0;
    res_ch.ready = 1'b0;
    cfg.deadband_mv = '0;
    cfg.clamp_mv = 15'd32767;
    cfg.pwm_gain_q16 = '0;
    cfg.slew_rate = '0;
    cfg.slew_enable = 1'b0;
    cfg.invert_mask = '0;
    drive_mode = MODE_BRAKING;
    left_tgt = '0;
    right_tgt = '0;
    left_app = '0;
    right_app = '0;
    requests_queued = 0;
    requests_taken = 0;
    mismatches = 0;
    idle_gaps = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: braking at start, zero gain, freewheel
    push_req(CMD_TICK, 0, 0, 123);
    push_req(CMD_SET, 1000, -1000, 0);
    push_req(CMD_TICK, 0, 0, 0);
    push_req(CMD_FREEWHEEL, 0, 0, 0);
    push_req(CMD_TICK, 0, 0, 65535);
    settle();

    // Deadband and clamp edges, most negative setpoint, slew steps
    configure(100, 20000, 800, 1024, 1, 2);
    push_req(CMD_SET, 32767, -32768, 0);
    push_req(CMD_TICK, 0, 0, 0);
    push_req(CMD_TICK, 0, 0, 5000);
    push_req(CMD_TICK, 0, 0, 65535);
    push_req(CMD_SET, 99, 100, 0);
    push_req(CMD_TICK, 0, 0, 100);
    push_req(CMD_TICK, 0, 0, 65535);
    push_req(CMD_SET, -20001, 20000, 0);
    push_req(CMD_TICK, 0, 0, 65535);
    push_req(CMD_BRAKE, 0, 0, 0);
    push_req(CMD_TICK, 0, 0, 7);
    push_req(CMD_SET, 0, 0, 0);
    push_req(CMD_TICK, 0, 0, 1);
    push_req(CMD_SET, -1, 1, 0);
    push_req(CMD_TICK, 0, 0, 0);
    settle();

    configure($urandom_range(0, 3000), $urandom_range(500, 32767),
              $urandom_range(200, 3000), $urandom_range(0, 65535), 1, $urandom_range(0, 3));
    queue_random(200);
    settle();

    // Widest settings, no idling on either side
    idle_gaps = 1'b0;
    configure(0, 32767, 1048575, 65535, 1, 3);
    queue_random(150);
    settle();

    // Narrowest settings
    idle_gaps = 1'b1;
    configure(32767, 0, 0, 0, 1, 0);
    queue_random(60);
    settle();

    configure($urandom_range(0, 3000), $urandom_range(500, 32767),
              $urandom_range(0, 4000), $urandom_range(0, 65535), 0, $urandom_range(0, 3));
    queue_random(160);
    settle();

    // Slow slew so the limiter bites over many ticks
    configure($urandom_range(0, 500), $urandom_range(2000, 32767),
              $urandom_range(300, 700), $urandom_range(0, 200), 1, $urandom_range(0, 3));
    queue_random(160);
    settle();

    idle_gaps = 1'b0;
    configure($urandom_range(0, 32767), $urandom_range(0, 32767),
              $urandom_range(0, 1048575), $urandom_range(0, 65535), $urandom_range(0, 1),
              $urandom_range(0, 3));
    queue_random(150);
    settle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
